// ===== src/shiprl_pkg.sv =====
// shared types and constants for the ship rrip/lip replacement unit
`default_nettype none
package shiprl_pkg;

  localparam int SET_MAX_W    = 13;
  localparam int WAY_MAX_W    = 5;
  localparam int ADDR_W       = 20;
  localparam int STRIDE_W     = 21;
  localparam int STREAK_W     = 4;
  localparam int SIG_W        = 6;
  localparam int SIG_COUNT    = 64;
  localparam int LEADER_COUNT = 32;
  localparam int LIP_OFFSET   = 32;

  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] RRPV_SRRIP   = 2'd2;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;
  localparam logic [1:0] REUSE_MAX    = 2'd3;

  localparam logic [STREAK_W-1:0] STREAK_MAX   = 4'd15;
  localparam logic [3:0]          THRESH_RESET = 4'd3;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // request after classification, as queued between front and back
  typedef struct packed {
    logic                 opcode;
    logic [SET_MAX_W-1:0] set_idx;
    logic [WAY_MAX_W-1:0] way;
    logic                 hit;
    logic [SIG_W-1:0]     sig;
    logic [ADDR_W-1:0]    addr;
    logic                 srrip_ldr;
    logic                 lip_ldr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   prev_addr;
    logic [STRIDE_W-1:0] prev_stride;
    logic [STREAK_W-1:0] streak;
  } strm_entry_t;

  // queue handshake from front to back
  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

endpackage
`default_nettype wire

// ===== src/shiprl_front.sv =====
// request front end: set/way reduction, signature hash, leader tagging and a two-entry queue
`default_nettype none
module shiprl_front import shiprl_pkg::*; #(
  parameter int SETS           = 2048,
  parameter int WAYS           = 16,
  parameter int LEADER_SPACING = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [10:0] in_set_index,
  input  wire logic [3:0]  in_way,
  input  wire logic        in_hit,
  input  wire logic [12:0] in_pc_low,
  input  wire logic [19:0] in_addr_low,
  input  wire logic        clr_busy,
  input  wire logic        q_pop,
  output q_head_t          q_head
);

  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = $clog2(WAYS);
  localparam int LSW   = $clog2(LEADER_SPACING);

  logic [SET_MAX_W-1:0] set_full;
  logic [SET_MAX_W-1:0] set_red;
  logic [WAY_MAX_W-1:0] way_full;
  logic [SET_MAX_W-1:0] ldr_grp;
  req_t                 req;
  logic                 accept;

  req_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    set_full      = SET_MAX_W'(in_set_index);
    set_red       = SET_MAX_W'(set_full[SET_W-1:0]);
    way_full      = WAY_MAX_W'(in_way);
    ldr_grp       = set_red >> LSW;
    req.opcode    = in_opcode;
    req.set_idx   = set_red;
    req.way       = WAY_MAX_W'(way_full[WAY_W-1:0]);
    req.hit       = in_hit;
    req.sig       = in_pc_low[7:2] ^ in_pc_low[12:7];
    req.addr      = in_addr_low;
    req.srrip_ldr = (set_red[LSW-1:0] == '0) && (ldr_grp < SET_MAX_W'(LEADER_COUNT));
    req.lip_ldr   = (set_red[LSW-1:0] == LSW'(LIP_OFFSET)) &&
                    (ldr_grp < SET_MAX_W'(LEADER_COUNT));
  end

  assign busy   = (cnt_r == 2'd2) || clr_busy;
  assign accept = start && !busy;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!accept && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        wp_r <= !wp_r;
      end
      if (q_pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wp_r] <= req;
    end
  end

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.req   = q_r[rp_r];

endmodule
`default_nettype wire

// ===== src/shiprl_back.sv =====
// execution back end: per-set state memories, aging, stream detector, predictor and selector
`default_nettype none
module shiprl_back import shiprl_pkg::*; #(
  parameter int SETS          = 2048,
  parameter int WAYS          = 16,
  parameter int SELECTOR_BITS = 10
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data,
  input  q_head_t         q_head,
  output logic            q_pop,
  output logic            clr_busy,
  output logic            out_valid,
  output logic [3:0]      out_victim_way,
  output logic [1:0]      out_new_rrpv,
  output logic            out_streaming
);

  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = $clog2(WAYS);
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = '1;
  localparam logic [SELECTOR_BITS-1:0] SEL_INIT = SEL_MAX >> 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  typedef logic [WAYS-1:0][1:0]       rrpv_row_t;
  typedef logic [WAYS-1:0][SIG_W-1:0] sig_row_t;

  rrpv_row_t   rrpv_mem  [SETS];
  sig_row_t    sig_mem   [SETS];
  strm_entry_t strm_mem  [SETS];
  logic [1:0]  reuse_mem [SIG_COUNT];

  rrpv_row_t   rrpv_rd;
  sig_row_t    sig_rd;
  strm_entry_t strm_rd;
  logic [1:0]  reuse_rd;

  logic [1:0]               state_r, state_nxt;
  req_t                     cur_r;
  logic [SET_W:0]           clr_addr_r;
  logic                     clr_active_r;
  logic [3:0]               thresh_r;
  logic [SELECTOR_BITS-1:0] sel_r, sel_nxt;
  logic [SIG_W-1:0]         ridx_r, ridx_nxt;
  logic                     flag_r, flag_nxt;
  strm_entry_t              strm_wd_r, strm_wd_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [3:0]       out_vw_r, out_vw_nxt;
  logic [1:0]       out_nr_r, out_nr_nxt;
  logic             out_st_r, out_st_nxt;

  logic [SET_W-1:0] set_a;
  logic [WAY_W-1:0] way_a;
  logic [SET_W-1:0] wr_addr;
  logic             rrpv_we, sig_we, strm_we, reuse_we;
  rrpv_row_t        rrpv_wd, aged;
  sig_row_t         sig_wd;
  strm_entry_t      strm_wd;
  logic [SIG_W-1:0] reuse_wa;
  logic [1:0]       reuse_wd;
  logic [1:0]       mx, age, nr, cnt_nxt;
  logic [WAY_W-1:0] victim;
  logic [WAY_MAX_W-1:0] victim_w;
  logic [STRIDE_W-1:0]  stride;
  logic [STREAK_W-1:0]  streak_inc;
  logic                 pick_srrip;
  logic [WAYS-1:0]      b1, b0;

  assign set_a = cur_r.set_idx[SET_W-1:0];
  assign way_a = cur_r.way[WAY_W-1:0];
  assign q_pop = (state_r == ST_IDLE) && q_head.valid && !clr_active_r;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    ridx_nxt      = ridx_r;
    flag_nxt      = flag_r;
    strm_wd_nxt   = strm_wd_r;
    out_valid_nxt = 1'b0;
    out_vw_nxt    = out_vw_r;
    out_nr_nxt    = out_nr_r;
    out_st_nxt    = out_st_r;
    rrpv_we       = 1'b0;
    sig_we        = 1'b0;
    strm_we       = 1'b0;
    reuse_we      = 1'b0;
    rrpv_wd       = rrpv_rd;
    sig_wd        = sig_rd;
    strm_wd       = strm_wd_r;
    reuse_wa      = ridx_r;
    reuse_wd      = reuse_rd;
    wr_addr       = set_a;
    nr            = RRPV_DISTANT;
    cnt_nxt       = reuse_rd;
    pick_srrip    = 1'b0;
    victim        = '0;

    // max rrpv of the set, then age so that at least one way reaches distant
    for (int i = 0; i < WAYS; i++) begin
      b1[i] = rrpv_rd[i][1];
      b0[i] = rrpv_rd[i][0];
    end
    mx[1] = |b1;
    mx[0] = mx[1] ? |(b1 & b0) : |b0;
    age   = RRPV_DISTANT - mx;
    for (int i = 0; i < WAYS; i++) begin
      aged[i] = rrpv_rd[i] + age;
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (aged[i] == RRPV_DISTANT) begin
        victim = WAY_W'(i);
      end
    end
    victim_w = WAY_MAX_W'(victim);

    stride     = {1'b0, cur_r.addr} - {1'b0, strm_rd.prev_addr};
    streak_inc = (strm_rd.streak < STREAK_MAX) ? strm_rd.streak + 4'd1 : strm_rd.streak;

    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (cur_r.opcode == OP_VICTIM) begin
          rrpv_we       = 1'b1;
          rrpv_wd       = aged;
          out_valid_nxt = 1'b1;
          out_vw_nxt    = victim_w[3:0];
          out_nr_nxt    = RRPV_NEAR;
          out_st_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          ridx_nxt = cur_r.hit ? sig_rd[way_a] : cur_r.sig;
          strm_wd_nxt.prev_addr = cur_r.addr;
          if ((strm_rd.streak != '0) && (stride == strm_rd.prev_stride) && (stride != '0)) begin
            strm_wd_nxt.prev_stride = strm_rd.prev_stride;
            strm_wd_nxt.streak      = streak_inc;
            flag_nxt                = (streak_inc >= thresh_r);
          end else begin
            strm_wd_nxt.prev_stride = stride;
            strm_wd_nxt.streak      = STREAK_W'(1);
            flag_nxt                = 1'b0;
          end
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        pick_srrip = cur_r.srrip_ldr ? 1'b1 : (cur_r.lip_ldr ? 1'b0 : (sel_r >= SEL_INIT));
        if (!cur_r.hit) begin
          nr      = (flag_r || reuse_rd == 2'd0) ? RRPV_DISTANT :
                    (pick_srrip ? RRPV_SRRIP : RRPV_DISTANT);
          cnt_nxt = (reuse_rd != 2'd0) ? reuse_rd - 2'd1 : reuse_rd;
          sig_we  = 1'b1;
          sig_wd[way_a] = cur_r.sig;
        end else begin
          nr      = RRPV_NEAR;
          cnt_nxt = (reuse_rd < REUSE_MAX) ? reuse_rd + 2'd1 : reuse_rd;
        end
        rrpv_we        = 1'b1;
        rrpv_wd[way_a] = nr;
        reuse_we       = 1'b1;
        reuse_wd       = cnt_nxt;
        strm_we        = 1'b1;
        // set dueling: leaders steer the selector toward the policy that misses less
        if (cur_r.srrip_ldr) begin
          if (cur_r.hit) begin
            if (sel_r < SEL_MAX) sel_nxt = sel_r + 1'b1;
          end else if (sel_r != '0) begin
            sel_nxt = sel_r - 1'b1;
          end
        end else if (cur_r.lip_ldr) begin
          if (cur_r.hit) begin
            if (sel_r != '0) sel_nxt = sel_r - 1'b1;
          end else if (sel_r < SEL_MAX) begin
            sel_nxt = sel_r + 1'b1;
          end
        end
        out_valid_nxt = 1'b1;
        out_vw_nxt    = 4'd0;
        out_nr_nxt    = nr;
        out_st_nxt    = flag_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // clearing pass owns every write port
    if (clr_active_r) begin
      wr_addr  = clr_addr_r[SET_W-1:0];
      rrpv_we  = 1'b1;
      rrpv_wd  = '1;
      sig_we   = 1'b1;
      sig_wd   = '0;
      strm_we  = 1'b1;
      strm_wd  = '0;
      reuse_we = 1'b1;
      reuse_wa = clr_addr_r[SIG_W-1:0];
      reuse_wd = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      thresh_r     <= THRESH_RESET;
      sel_r        <= SEL_INIT;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == (SET_W + 1)'(SETS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head.req;
    end
    ridx_r    <= ridx_nxt;
    flag_r    <= flag_nxt;
    strm_wd_r <= strm_wd_nxt;
    out_vw_r  <= out_vw_nxt;
    out_nr_r  <= out_nr_nxt;
    out_st_r  <= out_st_nxt;
  end

  // set-indexed memories, read when a transaction is popped
  always_ff @(posedge clk) begin
    if (rrpv_we) begin
      rrpv_mem[wr_addr] <= rrpv_wd;
    end
    if (q_pop) begin
      rrpv_rd <= rrpv_mem[q_head.req.set_idx[SET_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (sig_we) begin
      sig_mem[wr_addr] <= sig_wd;
    end
    if (q_pop) begin
      sig_rd <= sig_mem[q_head.req.set_idx[SET_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (strm_we) begin
      strm_mem[wr_addr] <= strm_wd;
    end
    if (q_pop) begin
      strm_rd <= strm_mem[q_head.req.set_idx[SET_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (reuse_we) begin
      reuse_mem[reuse_wa] <= reuse_wd;
    end
    if (state_r == ST_CALC) begin
      reuse_rd <= reuse_mem[ridx_nxt];
    end
  end

  assign clr_busy       = clr_active_r;
  assign out_valid      = out_valid_r;
  assign out_victim_way = out_vw_r;
  assign out_new_rrpv   = out_nr_r;
  assign out_streaming  = out_st_r;

endmodule
`default_nettype wire

// ===== src/ship_rrip_lip_replacement_unit.sv =====
// top level of the ship rrip/lip replacement unit
//
//  channel  | ports                                              | handshake
//  request  | in_opcode in_set_index in_way in_hit in_pc_low     | start & !busy
//           | in_addr_low                                        |
//  result   | out_victim_way out_new_rrpv out_streaming          | out_valid, one cycle
//  config   | cfg_wr_data                                        | cfg_wr_en
//
// a victim request passes through row read and compute, an update through row read, compute and
// reuse counter read, and write back, and the result is registered; one transaction at a time in the back
// a two-entry queue lets the front accept while the back end works; busy when it is full
// after reset a clearing pass writes one set per cycle until all SETS sets are cleared, busy meanwhile
// results cannot be stalled by the receiver
`default_nettype none
module ship_rrip_lip_replacement_unit import shiprl_pkg::*; #(
  parameter int SETS           = 2048,
  parameter int WAYS           = 16,
  parameter int LEADER_SPACING = 64,
  parameter int SELECTOR_BITS  = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [10:0] in_set_index,
  input  wire logic [3:0]  in_way,
  input  wire logic        in_hit,
  input  wire logic [12:0] in_pc_low,
  input  wire logic [19:0] in_addr_low,
  output logic             out_valid,
  output logic [3:0]       out_victim_way,
  output logic [1:0]       out_new_rrpv,
  output logic             out_streaming,
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data
);

  q_head_t q_head;
  logic    q_pop;
  logic    clr_busy;

  shiprl_front #(
    .SETS(SETS), .WAYS(WAYS), .LEADER_SPACING(LEADER_SPACING)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_set_index(in_set_index), .in_way(in_way),
    .in_hit(in_hit), .in_pc_low(in_pc_low), .in_addr_low(in_addr_low),
    .clr_busy(clr_busy), .q_pop(q_pop), .q_head(q_head)
  );

  shiprl_back #(
    .SETS(SETS), .WAYS(WAYS), .SELECTOR_BITS(SELECTOR_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .q_head(q_head), .q_pop(q_pop), .clr_busy(clr_busy),
    .out_valid(out_valid), .out_victim_way(out_victim_way),
    .out_new_rrpv(out_new_rrpv), .out_streaming(out_streaming)
  );

endmodule
`default_nettype wire

// ===== src/shiprl_checker.sv =====
// port-level checks for the replacement unit and their bind
`default_nettype none
module shiprl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [3:0] out_victim_way,
  input wire logic [1:0] out_new_rrpv,
  input wire logic       out_streaming
);

  // clearing pass starts right after reset
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

  // every transaction needs at least the compute state before the next result
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in consecutive cycles");

  a_srrip_not_streaming: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_new_rrpv == 2'd2) |-> !out_streaming && (out_victim_way == 4'd0))
    else $error("srrip insertion on a streaming set or victim result");

endmodule

bind ship_rrip_lip_replacement_unit shiprl_checker u_shiprl_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_victim_way(out_victim_way), .out_new_rrpv(out_new_rrpv),
  .out_streaming(out_streaming)
);
`default_nettype wire
